// ===== rtl/ethernet_fcs_framer_checker_defines.svh =====
// Assertion macros for the Ethernet FCS framer and checker.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ETHERNET_FCS_FRAMER_CHECKER_DEFINES_SVH
`define ETHERNET_FCS_FRAMER_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define EFCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efcs assertion failed");
`define EFCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efcs assertion failed");
`else
`define EFCS_ASSERT_SAME(label, ante, cons)
`define EFCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/efcs_pkg.sv =====
// Package for the Ethernet FCS framer and checker: constants, payload types,
// tail state encoding and the byte-wide reflected CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package efcs_pkg;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_RESIDUE     = 32'hDEBB_20E3;
    localparam logic [5:0]  COUNT_MAX       = 6'd63;
    localparam logic [5:0]  MIN_FRAME_BYTES = 6'd60;
    localparam logic [5:0]  MIN_CHECK_BYTES = 6'd4;
    localparam logic [1:0]  FCS_LAST_IDX    = 2'd3;

    localparam logic [1:0] CFG_CHECK_MODE = 2'd0;
    localparam logic [1:0] CFG_APPEND_FCS = 2'd1;
    localparam logic [1:0] CFG_PAD_SHORT  = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_FCS  = 2'd2;

    typedef enum logic [1:0] {
        ST_PASS,
        ST_PAD,
        ST_FCS
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       out_last;
        logic       fcs_good;
    } out_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [5:0] count_inc(input logic [5:0] c);
        return (c == COUNT_MAX) ? c : c + 6'd1;
    endfunction

endpackage

// ===== rtl/ethernet_fcs_framer_checker.sv =====
// Ethernet FCS framer and checker top level: one input buffer, CRC and tail
// sequencer, output register. Depends on efcs_pkg and the defines header.
//
//   channel | signals                          | carries
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_stall, in_data      | one frame byte and last flag
//   out     | out_valid, out_stall, out_data   | byte, kind, last, fcs_good
//   cfg     | cfg_wen, cfg_index, cfg_data     | check_mode, append_fcs, pad_short
//
// One byte per cycle when not stalled, through a single CRC byte update between
// the input buffer and the output register. A generated frame tail adds up to
// 59 pad bytes and four FCS bytes; the input buffer fills and stalls
// meanwhile. Reset clears CRC to all ones, count to zero, both buffers empty.
// An output stall holds the output register; the input buffer still takes one.
`timescale 1ns / 1ps
`include "ethernet_fcs_framer_checker_defines.svh"

module ethernet_fcs_framer_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  efcs_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output efcs_pkg::out_item_t out_data,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_index,
    input  logic               cfg_data
);

    logic                check_mode_reg;
    logic                append_fcs_reg;
    logic                pad_short_reg;

    logic                in_full_reg;
    logic                in_full_next;
    efcs_pkg::in_item_t  in_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    efcs_pkg::out_item_t out_reg;
    efcs_pkg::out_item_t out_next;

    efcs_pkg::state_t    state_reg;
    efcs_pkg::state_t    state_next;
    logic [31:0]         crc_reg;
    logic [31:0]         crc_next;
    logic [5:0]          count_reg;
    logic [5:0]          count_next;
    logic [1:0]          fcs_idx_reg;
    logic [1:0]          fcs_idx_next;

    logic                out_free;
    logic                consume;
    logic                accept;
    logic                emit;
    logic [31:0]         crc_step;
    logic [5:0]          count_step;
    logic [31:0]         fcs_word;
    logic                need_pad;

    assign out_free  = !out_valid_reg || !out_stall;
    assign consume   = (state_reg == efcs_pkg::ST_PASS) && in_full_reg && out_free;
    assign in_stall  = in_full_reg && !consume;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign fcs_word  = ~crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg <= 1'b0;
            append_fcs_reg <= 1'b1;
            pad_short_reg  <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                efcs_pkg::CFG_CHECK_MODE: check_mode_reg <= cfg_data;
                efcs_pkg::CFG_APPEND_FCS: append_fcs_reg <= cfg_data;
                efcs_pkg::CFG_PAD_SHORT:  pad_short_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (consume)
        begin
            in_full_next = 1'b0;
        end
        if (accept)
        begin
            in_full_next = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        fcs_idx_next   = fcs_idx_reg;
        emit           = 1'b0;
        out_next       = out_reg;
        crc_step       = efcs_pkg::crc_byte(crc_reg, 8'd0);
        count_step     = efcs_pkg::count_inc(count_reg);
        need_pad       = 1'b0;

        case (state_reg)
            efcs_pkg::ST_PASS:
            begin
                crc_step = efcs_pkg::crc_byte(crc_reg, in_reg.data_byte);
                if (consume)
                begin
                    emit              = 1'b1;
                    out_next.out_byte = in_reg.data_byte;
                    out_next.out_kind = efcs_pkg::KIND_DATA;
                    out_next.out_last = in_reg.last_byte;
                    out_next.fcs_good = 1'b0;
                    crc_next          = crc_step;
                    count_next        = count_step;
                    if (check_mode_reg)
                    begin
                        if (in_reg.last_byte)
                        begin
                            out_next.fcs_good = (count_step >= efcs_pkg::MIN_CHECK_BYTES)
                                                && (crc_step == efcs_pkg::CRC_RESIDUE);
                            crc_next   = efcs_pkg::CRC_INIT;
                            count_next = 6'd0;
                        end
                    end
                    else if (in_reg.last_byte)
                    begin
                        need_pad = pad_short_reg && (count_step < efcs_pkg::MIN_FRAME_BYTES);
                        out_next.out_last = !need_pad && !append_fcs_reg;
                        if (need_pad)
                        begin
                            state_next = efcs_pkg::ST_PAD;
                        end
                        else if (append_fcs_reg)
                        begin
                            state_next   = efcs_pkg::ST_FCS;
                            fcs_idx_next = 2'd0;
                        end
                        else
                        begin
                            crc_next   = efcs_pkg::CRC_INIT;
                            count_next = 6'd0;
                        end
                    end
                end
            end
            efcs_pkg::ST_PAD:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    out_next.out_byte = 8'd0;
                    out_next.out_kind = efcs_pkg::KIND_PAD;
                    out_next.out_last = !append_fcs_reg
                                        && (count_step >= efcs_pkg::MIN_FRAME_BYTES);
                    out_next.fcs_good = 1'b0;
                    crc_next          = crc_step;
                    count_next        = count_step;
                    if (count_step >= efcs_pkg::MIN_FRAME_BYTES)
                    begin
                        if (append_fcs_reg)
                        begin
                            state_next   = efcs_pkg::ST_FCS;
                            fcs_idx_next = 2'd0;
                        end
                        else
                        begin
                            state_next = efcs_pkg::ST_PASS;
                            crc_next   = efcs_pkg::CRC_INIT;
                            count_next = 6'd0;
                        end
                    end
                end
            end
            efcs_pkg::ST_FCS:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    out_next.out_byte = fcs_word[{fcs_idx_reg, 3'b000} +: 8];
                    out_next.out_kind = efcs_pkg::KIND_FCS;
                    out_next.out_last = (fcs_idx_reg == efcs_pkg::FCS_LAST_IDX);
                    out_next.fcs_good = 1'b0;
                    fcs_idx_next      = fcs_idx_reg + 2'd1;
                    if (fcs_idx_reg == efcs_pkg::FCS_LAST_IDX)
                    begin
                        state_next = efcs_pkg::ST_PASS;
                        crc_next   = efcs_pkg::CRC_INIT;
                        count_next = 6'd0;
                    end
                end
            end
            default:
            begin
                state_next = efcs_pkg::ST_PASS;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= efcs_pkg::ST_PASS;
            crc_reg       <= efcs_pkg::CRC_INIT;
            count_reg     <= 6'd0;
            fcs_idx_reg   <= 2'd0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            fcs_idx_reg   <= fcs_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    `EFCS_ASSERT_SAME(a_good_only_on_last, out_valid_reg && out_reg.fcs_good, out_reg.out_last)
    `EFCS_ASSERT_SAME(a_tail_holds_output, state_reg != efcs_pkg::ST_PASS, out_valid_reg)
    `EFCS_ASSERT_SAME(a_no_take_in_tail, state_reg != efcs_pkg::ST_PASS, !consume)
    `EFCS_ASSERT_NEXT(a_crc_restart, state_reg == efcs_pkg::ST_FCS && fcs_idx_reg == efcs_pkg::FCS_LAST_IDX && out_free, state_reg == efcs_pkg::ST_PASS && crc_reg == efcs_pkg::CRC_INIT && count_reg == 6'd0)

endmodule

// ===== test/ethernet_fcs_framer_checker_tb.sv =====
// Testbench for ethernet_fcs_framer_checker: drives frame bytes with random idling and
// back-pressure, predicts pass, pad and FCS bytes and the check flag, and compares them.
// Depends on efcs_pkg and the ethernet_fcs_framer_checker RTL.
`timescale 1ns / 1ps

module ethernet_fcs_framer_checker_tb;

    import efcs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_RESULTS = 64;
    localparam int PHASE_ITEMS = 30;
    localparam int NUM_PHASES  = 7;
    localparam int MAX_REPORTS = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = CFG_CHECK_MODE;
    logic        cfg_data  = 1'b0;

    // configuration mirror and running frame state
    logic        mode_check  = 1'b0;
    logic        mode_append = 1'b1;
    logic        mode_pad    = 1'b1;
    logic [31:0] run_crc     = CRC_INIT;
    logic [5:0]  run_count   = '0;

    in_item_t    tx_byte_q[$];
    out_item_t   expected_out_q[$];
    int          queued_count   = 0;
    int          accepted_count = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    bit          in_taken       = 1'b0;
    bit          idle_on        = 1'b1;
    bit          hold_req       = 1'b0;
    int          hold_left      = 0;
    int          in_gap         = 0;
    int          out_gap        = 0;

    // {check_mode, append_fcs, pad_short} per random phase
    logic [2:0]  phase_cfg [0:NUM_PHASES-1] =
        '{3'b011, 3'b000, 3'b111, 3'b010, 3'b100, 3'b001, 3'b011};

    ethernet_fcs_framer_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] fcs_crc_next(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic absorb_byte(logic [7:0] b);
        run_crc = fcs_crc_next(run_crc, b);
        if (run_count != COUNT_MAX)
        begin
            run_count = run_count + 6'd1;
        end
    endtask

    task automatic push_result(logic [7:0] b, logic [1:0] kind, logic last, logic good);
        out_item_t r;
        r.out_byte = b;
        r.out_kind = kind;
        r.out_last = last;
        r.fcs_good = good;
        expected_out_q.insert(expected_out_q.size(), r);
    endtask

    task automatic predict_frame_byte(in_item_t req);
        logic [31:0] fcs;
        logic [7:0]  fb;
        logic        good;
        int          n;
        absorb_byte(req.data_byte);
        if (mode_check)
        begin
            good = 1'b0;
            if (req.last_byte)
            begin
                good = (run_count >= MIN_CHECK_BYTES) && (run_crc == CRC_RESIDUE);
                run_crc = CRC_INIT;
                run_count = '0;
            end
            push_result(req.data_byte, KIND_DATA, req.last_byte, good);
        end
        else if (!req.last_byte)
        begin
            push_result(req.data_byte, KIND_DATA, 1'b0, 1'b0);
        end
        else
        begin
            push_result(req.data_byte, KIND_DATA,
                        !(mode_pad && run_count < MIN_FRAME_BYTES) && !mode_append, 1'b0);
            n = 1;
            // pad with zeros, bounded so one frame end never exceeds the result limit
            while (mode_pad && run_count < MIN_FRAME_BYTES && n < MAX_RESULTS - 4)
            begin
                absorb_byte(8'h00);
                n++;
                push_result(8'h00, KIND_PAD,
                            !mode_append && (run_count >= MIN_FRAME_BYTES ||
                                             n >= MAX_RESULTS - 4), 1'b0);
            end
            if (mode_append)
            begin
                fcs = ~run_crc;
                for (int i = 0; i < 4; i++)
                begin
                    fb = fcs[8*i +: 8];
                    absorb_byte(fb);
                    push_result(fb, KIND_FCS, i == FCS_LAST_IDX, 1'b0);
                end
            end
            run_crc = CRC_INIT;
            run_count = '0;
        end
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (error_count < MAX_REPORTS)
        begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic queue_byte(logic [7:0] b, logic last);
        in_item_t req;
        req.data_byte = b;
        req.last_byte = last;
        tx_byte_q.insert(tx_byte_q.size(), req);
        queued_count++;
    endtask

    task automatic queue_random_frame(int len);
        for (int i = 0; i < len; i++)
        begin
            queue_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // payload followed by its FCS, optionally with one bit flipped anywhere
    task automatic queue_checked_frame(int payload_len, bit corrupt);
        logic [7:0]  frame[$];
        logic [31:0] crc;
        int          pos;
        crc = CRC_INIT;
        for (int i = 0; i < payload_len; i++)
        begin
            frame.insert(frame.size(), 8'($urandom_range(0, 255)));
            crc = fcs_crc_next(crc, frame[i]);
        end
        crc = ~crc;
        for (int i = 0; i < 4; i++)
        begin
            frame.insert(frame.size(), crc[8*i +: 8]);
        end
        if (corrupt)
        begin
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (frame[i])
        begin
            queue_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    task automatic queue_random_phase(int budget);
        int start;
        int len;
        int pick;
        start = queued_count;
        while (queued_count - start < budget)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 80) : $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            if (!mode_check)
            begin
                queue_random_frame(len);
            end
            else if (pick < 6)
            begin
                queue_checked_frame(len - 1, 1'b0);
            end
            else if (pick < 8)
            begin
                queue_checked_frame(len - 1, 1'b1);
            end
            else
            begin
                queue_random_frame($urandom_range(1, 6));
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            CFG_CHECK_MODE: mode_check  = val;
            CFG_APPEND_FCS: mode_append = val;
            CFG_PAD_SHORT:  mode_pad    = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic check, logic append, logic pad);
        write_reg(CFG_CHECK_MODE, check);
        write_reg(CFG_APPEND_FCS, append);
        write_reg(CFG_PAD_SHORT, pad);
    endtask

    task automatic wait_drained();
        while (tx_byte_q.size() != 0 || accepted_count != queued_count ||
               expected_out_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // sender: hold a stalled request, otherwise idle in bursts or offer the next byte
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                in_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (tx_byte_q.size() != 0)
            begin
                in_data  <= tx_byte_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off on request, otherwise random stall bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_gap = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ethernet_fcs_framer_checker_tb: FAIL");
            $finish;
        end
        else
        begin
            in_taken = rst_n && in_valid && !in_stall;
            if (in_taken)
            begin
                predict_frame_byte(in_data);
                accepted_count++;
            end
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_out_q.size() == 0)
                begin
                    report_mismatch("unexpected result byte", out_data.out_byte, 8'h00);
                end
                else
                begin
                    want = expected_out_q.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 8'(out_data.out_kind),
                                        8'(want.out_kind));
                    if (out_data.out_last !== want.out_last)
                        report_mismatch("out_last", 8'(out_data.out_last),
                                        8'(want.out_last));
                    if (out_data.fcs_good !== want.fcs_good)
                        report_mismatch("fcs_good", 8'(out_data.fcs_good),
                                        8'(want.fcs_good));
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: a single-byte and a three-byte frame, padded to minimum, then FCS
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b1);
        wait_drained();

        set_config(1'b0, 1'b0, 1'b0);
        queue_byte(8'hA5, 1'b1);
        queue_byte(8'h5A, 1'b1);
        wait_drained();

        set_config(1'b0, 1'b1, 1'b0);
        queue_byte(8'h3C, 1'b1);
        wait_drained();

        set_config(1'b0, 1'b0, 1'b1);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h81, 1'b1);
        wait_drained();

        // check mode: empty payload with FCS, too-short frames, a good frame,
        // then leave a frame open across the switch back to generate mode
        set_config(1'b1, 1'b1, 1'b1);
        queue_random_frame(0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h5A, 1'b1);
        queue_random_frame(3);
        queue_checked_frame(2, 1'b0);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        wait_drained();

        set_config(1'b0, 1'b1, 1'b1);
        queue_byte(8'h33, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_on = (p != NUM_PHASES - 1);
            set_config(phase_cfg[p][2], phase_cfg[p][1], phase_cfg[p][0]);
            queue_random_phase(PHASE_ITEMS);
            if (p == 1 || p == 4)
            begin
                @(posedge clk);
                hold_req = 1'b1;
            end
            wait_drained();
        end

        if (error_count == 0)
        begin
            $display("ethernet_fcs_framer_checker_tb: PASS");
        end
        else
        begin
            $display("ethernet_fcs_framer_checker_tb: FAIL");
        end
        $finish;
    end

endmodule
